// ===== hw/rtl/afs_pkg.sv =====
// afs_pkg: widths, codes and controller/datapath handshake types for the
// animation frame sequencer. No dependencies; every other file imports it.

package afs_pkg;

   // table depth, fixed by the 6-bit frame fields
   localparam int MAX_FRAMES = 64;

   // field and internal widths
   localparam int ACTION_W   = 3;
   localparam int ELAPSED_W  = 24;
   localparam int IDX_W      = 6;
   localparam int MS_W       = 16;
   localparam int FRAME_W    = 7;
   localparam int COUNT_W    = 7;
   localparam int US_W       = 26;
   localparam int ACC_W      = 27;
   localparam int ADV_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // constants
   localparam logic [9:0]         US_PER_MS      = 10'd1000;
   localparam logic [US_W-1:0]    BASE_US_RESET  = 26'd100000;
   localparam logic [MS_W-1:0]    BASE_MS_RESET  = 16'd100;
   localparam logic [COUNT_W-1:0] COUNT_RESET    = 7'd1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK       = 3'd0,
      ACT_SET_FRAME  = 3'd1,
      ACT_PLAY       = 3'd2,
      ACT_PAUSE      = 3'd3,
      ACT_SET_BASE   = 3'd4,
      ACT_WRITE_TIME = 3'd5,
      ACT_RESTART    = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      MODE_LOOP      = 2'd0,
      MODE_PING_PONG = 2'd1,
      MODE_ONCE      = 2'd2,
      MODE_STATIC    = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANIM_MODE     = 2'd0,
      CSR_FRAME_COUNT   = 2'd1,
      CSR_BASE_RESET    = 2'd2,
      CSR_START_PLAYING = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_WRAP,
      ST_DONE
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;     // execute the word on the request channel
      logic step;       // one advance iteration of a tick
      logic wrap;       // reduce a loop frame that is still beyond the count
      logic load_out;   // copy result into the response register
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic tick_go;      // request is a tick that has work to do
      logic take;         // accumulator covers the current frame duration
      logic at_limit;     // advance budget used up
      logic once_end;     // play once sits on its last frame
      logic wrap_more;    // loop advance leaves a frame beyond the count
      logic wrap_pending; // current frame still beyond the count
   } dp_status_type;

endpackage

// ===== hw/rtl/afs_req_if.sv =====
// afs_req_if: request channel of the frame sequencer, valid/ready plus the
// action word. Depends on afs_pkg.

interface afs_req_if import afs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ACTION_W-1:0]  action;
   logic [ELAPSED_W-1:0] elapsed_us;
   logic [IDX_W-1:0]     target_idx;
   logic [MS_W-1:0]      time_ms;

   modport source (output valid, output action, output elapsed_us,
                   output target_idx, output time_ms, input ready);
   modport sink   (input valid, input action, input elapsed_us,
                   input target_idx, input time_ms, output ready);
endinterface

// ===== hw/rtl/afs_rsp_if.sv =====
// afs_rsp_if: response channel of the frame sequencer, valid/ready plus the
// result word. Depends on afs_pkg.

interface afs_rsp_if import afs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] shown_frame;
   logic             frame_changed;
   logic             accepted;
   logic             is_playing;

   modport source (output valid, output shown_frame, output frame_changed,
                   output accepted, output is_playing, input ready);
   modport sink   (input valid, input shown_frame, input frame_changed,
                   input accepted, input is_playing, output ready);
endinterface

// ===== hw/rtl/afs_datapath.sv =====
// afs_datapath: configuration registers, frame/timer state, duration table
// memory, the ms-to-us multiplier and the advance logic.
// Depends on afs_pkg; driven by afs_controller through dp_cmd_type.

module afs_datapath import afs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [ELAPSED_W-1:0]  req_elapsed_us,
   input  logic [IDX_W-1:0]      req_target_idx,
   input  logic [MS_W-1:0]       req_time_ms,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output logic [IDX_W-1:0]      out_shown_frame,
   output logic                  out_frame_changed,
   output logic                  out_accepted,
   output logic                  out_is_playing
);

   localparam int                 ADDR_W = $clog2(MAX_FRAMES);
   localparam logic [8:0]         MAX_F  = 9'(MAX_FRAMES);
   localparam logic [COUNT_W-1:0] MAX_N  = COUNT_W'(MAX_FRAMES);

   // configuration
   mode_type              mode_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic [MS_W-1:0]       base_reset_ff;
   logic                  start_ff;

   // sequencer state
   logic [FRAME_W-1:0]    frame_ff, frame_in;
   logic                  down_ff, down_in;
   logic                  running_ff, running_in;
   logic [ACC_W-1:0]      accum_ff, accum_in;
   logic [US_W-1:0]       base_us_ff, base_us_in;
   logic [ADV_W-1:0]      adv_ff, adv_in;
   logic [FRAME_W-1:0]    prev_ff;
   logic                  ok_ff, ok_in;

   // duration table, stored in microseconds
   logic [US_W-1:0]       table_mem [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] valid_ff;
   logic [US_W-1:0]       rd_data_ff;
   logic                  rd_valid_ff;
   logic [ADDR_W+FRAME_W-1:0] rd_wide;
   logic [ADDR_W+IDX_W-1:0]   wr_wide;
   logic [ADDR_W-1:0]     rd_addr, wr_addr;
   logic                  mem_we;

   // combinational helpers
   action_type            act;
   logic [COUNT_W-1:0]    n, n_minus1;
   logic [ADV_W-1:0]      limit;
   logic [FRAME_W-1:0]    idx7;
   logic                  set_ok, wr_ok;
   logic [MS_W-1:0]       mult_a;
   logic [US_W-1:0]       prod;
   logic [US_W-1:0]       ft;
   logic [ADV_W-1:0]      inc, dec, wrapped, step_val;
   logic                  below;
   logic [FRAME_W-1:0]    nxt_frame;
   logic                  nxt_down;
   logic                  wrap_more;
   logic [FRAME_W-1:0]    wrap_val;

   assign act  = action_type'(req_action);
   assign idx7 = {1'b0, req_target_idx};

   // effective frame count, clamped to 1..MAX_FRAMES
   always_comb begin
      if (count_ff == '0) begin
         n = COUNT_W'(1);
      end else if ({2'b00, count_ff} > MAX_F) begin
         n = MAX_N;
      end else begin
         n = count_ff;
      end
   end
   assign n_minus1 = n - COUNT_W'(1);
   assign limit    = {n, 1'b0};

   assign set_ok = idx7 < n;
   assign wr_ok  = {3'b000, req_target_idx} < MAX_F;

   // shared ms to us multiplier: table write, set base and restart
   always_comb begin
      case (act)
         ACT_WRITE_TIME: begin
            mult_a = req_time_ms;
         end
         ACT_SET_BASE: begin
            mult_a = (req_time_ms == '0) ? MS_W'(1) : req_time_ms;
         end
         default: begin
            mult_a = (base_reset_ff == '0) ? MS_W'(1) : base_reset_ff;
         end
      endcase
   end
   assign prod = {10'd0, mult_a} * {16'd0, US_PER_MS};

   // memory addressing, read follows the next frame so data lines up
   assign rd_wide = {{ADDR_W{1'b0}}, frame_in};
   assign rd_addr = rd_wide[ADDR_W-1:0];
   assign wr_wide = {{ADDR_W{1'b0}}, req_target_idx};
   assign wr_addr = wr_wide[ADDR_W-1:0];
   assign mem_we  = cmd.accept && (act == ACT_WRITE_TIME) && wr_ok;

   // duration of the current frame
   always_comb begin
      if (rd_valid_ff && (frame_ff < n) && (rd_data_ff != '0)) begin
         ft = rd_data_ff;
      end else begin
         ft = base_us_ff;
      end
   end

   // next frame for one advance
   assign inc = {1'b0, frame_ff} + ADV_W'(1);
   assign dec = {1'b0, frame_ff} - ADV_W'(1);
   assign wrapped  = inc - {1'b0, n};
   assign step_val = down_ff ? dec : inc;
   assign below    = down_ff && (frame_ff == '0);

   always_comb begin
      nxt_frame = frame_ff;
      nxt_down  = down_ff;
      wrap_more = 1'b0;
      case (mode_ff)
         MODE_LOOP: begin
            if (inc >= {1'b0, n}) begin
               nxt_frame = wrapped[FRAME_W-1:0];
               wrap_more = wrapped >= {1'b0, n};
            end else begin
               nxt_frame = inc[FRAME_W-1:0];
            end
         end
         MODE_PING_PONG: begin
            if (!below && (step_val >= {1'b0, n_minus1})) begin
               nxt_frame = n_minus1;
               nxt_down  = 1'b1;
            end else if (below || (step_val == '0)) begin
               nxt_frame = '0;
               nxt_down  = 1'b0;
            end else begin
               nxt_frame = step_val[FRAME_W-1:0];
            end
         end
         MODE_ONCE: begin
            nxt_frame = inc[FRAME_W-1:0];
         end
         default: begin
            nxt_frame = frame_ff;
         end
      endcase
   end

   assign wrap_val = frame_ff - n;

   // status towards the controller
   assign status.tick_go = (act == ACT_TICK) && (req_elapsed_us != '0) &&
                           (mode_ff != MODE_STATIC) && running_ff &&
                           (n >= COUNT_W'(2));
   assign status.take         = {1'b0, ft} <= accum_ff;
   assign status.at_limit     = adv_ff >= limit;
   assign status.once_end     = (mode_ff == MODE_ONCE) && (frame_ff >= n_minus1);
   assign status.wrap_more    = wrap_more;
   assign status.wrap_pending = frame_ff >= n;

   // next state of the sequencer
   always_comb begin
      frame_in   = frame_ff;
      down_in    = down_ff;
      running_in = running_ff;
      accum_in   = accum_ff;
      base_us_in = base_us_ff;
      adv_in     = adv_ff;
      ok_in      = ok_ff;
      if (cmd.accept) begin
         adv_in = '0;
         ok_in  = 1'b1;
         case (act)
            ACT_TICK: begin
               if (status.tick_go) begin
                  accum_in = accum_ff + ACC_W'(req_elapsed_us);
               end
            end
            ACT_SET_FRAME: begin
               ok_in = set_ok;
               if (set_ok && (idx7 != frame_ff)) begin
                  frame_in = idx7;
                  accum_in = '0;
               end
            end
            ACT_PLAY: begin
               running_in = 1'b1;
            end
            ACT_PAUSE: begin
               running_in = 1'b0;
            end
            ACT_SET_BASE: begin
               base_us_in = prod;
            end
            ACT_WRITE_TIME: begin
               ok_in = wr_ok;
            end
            ACT_RESTART: begin
               frame_in   = '0;
               down_in    = 1'b0;
               accum_in   = '0;
               base_us_in = prod;
               running_in = start_ff && (mode_ff != MODE_STATIC);
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
      // one advance iteration
      if (cmd.step && status.take) begin
         if (status.at_limit) begin
            accum_in = '0;
         end else if (status.once_end) begin
            running_in = 1'b0;
            accum_in   = '0;
         end else begin
            adv_in   = adv_ff + ADV_W'(1);
            accum_in = accum_ff - {1'b0, ft};
            frame_in = nxt_frame;
            down_in  = nxt_down;
         end
      end
      if (cmd.wrap) begin
         frame_in = wrap_val;
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_LOOP;
         count_ff      <= COUNT_RESET;
         base_reset_ff <= BASE_MS_RESET;
         start_ff      <= 1'b1;
         frame_ff      <= '0;
         down_ff       <= 1'b0;
         running_ff    <= 1'b1;
         accum_ff      <= '0;
         base_us_ff    <= BASE_US_RESET;
         valid_ff      <= '0;
      end else begin
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_ANIM_MODE:     mode_ff       <= mode_type'(csr_wdata[1:0]);
               CSR_FRAME_COUNT:   count_ff      <= csr_wdata[COUNT_W-1:0];
               CSR_BASE_RESET:    base_reset_ff <= csr_wdata[MS_W-1:0];
               CSR_START_PLAYING: start_ff      <= csr_wdata[0];
               default: begin
                  start_ff <= start_ff;
               end
            endcase
         end
         frame_ff   <= frame_in;
         down_ff    <= down_in;
         running_ff <= running_in;
         accum_ff   <= accum_in;
         base_us_ff <= base_us_in;
         if (mem_we) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // table memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[wr_addr] <= prod;
      end
      rd_data_ff  <= table_mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   // per-word bookkeeping and the response register
   always_ff @(posedge clock) begin
      adv_ff <= adv_in;
      ok_ff  <= ok_in;
      if (cmd.accept) begin
         prev_ff <= frame_ff;
      end
      if (cmd.load_out) begin
         out_shown_frame   <= frame_ff[IDX_W-1:0];
         out_frame_changed <= frame_ff != prev_ff;
         out_accepted      <= ok_ff;
         out_is_playing    <= running_ff;
      end
   end

   // frame never points past the table
   a_frame_in_table: assert property (@(posedge clock) disable iff (reset)
      {2'b00, frame_ff} < MAX_F)
      else $error("frame beyond table depth");

   // advance count stays within the budget of a tick
   a_adv_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> adv_ff <= limit)
      else $error("advance count over limit");

   // timer only stops on pause, restart or the end of a play once run
   a_running_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(running_ff) |-> $past(cmd.accept) ||
                            $past(cmd.step && (mode_ff == MODE_ONCE)))
      else $error("timer stopped without cause");

   // base duration is never zero
   a_base_nonzero: assert property (@(posedge clock) disable iff (reset)
      base_us_ff != '0)
      else $error("zero base duration");

endmodule

// ===== hw/rtl/afs_controller.sv =====
// afs_controller: state machine that accepts a word, runs the advance loop
// of a tick and hands the result to the response register.
// Depends on afs_pkg; drives afs_datapath through dp_cmd_type.

module afs_controller import afs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctl_state_type state_ff, state_in;
   logic          out_valid_ff, out_valid_in;
   logic          slot_free;

   assign slot_free = !out_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.tick_go ? ST_STEP : ST_DONE;
            end
         end
         ST_STEP: begin
            if (!status.take || status.at_limit || status.once_end) begin
               state_in = ST_DONE;
            end else if (status.wrap_more) begin
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            if (!status.wrap_pending) begin
               state_in = ST_STEP;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
         end
         ST_WRAP: begin
            cmd.wrap = status.wrap_pending;
         end
         ST_DONE: begin
            cmd.load_out = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // response valid flag
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== hw/rtl/animation_frame_sequencer_unit.sv =====
// animation_frame_sequencer_unit: one word in, one result word out.
// Sequence: a non-tick word is accepted and then loaded into the response
// register; a tick runs the advance loop in between, with wrap steps when a
// loop frame sits beyond a lowered count; the load waits while rsp_ready is
// low. One word at a time, at most 2 * frame_count advances per tick.
// Synchronous active-high reset; table valid bits clear at once.

module animation_frame_sequencer_unit import afs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   afs_req_if.sink               req_ch,
   afs_rsp_if.source             rsp_ch
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencing control
   afs_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // state, table and arithmetic
   afs_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_action        (req_ch.action),
      .req_elapsed_us    (req_ch.elapsed_us),
      .req_target_idx    (req_ch.target_idx),
      .req_time_ms       (req_ch.time_ms),
      .cmd               (cmd),
      .status            (status),
      .out_shown_frame   (rsp_ch.shown_frame),
      .out_frame_changed (rsp_ch.frame_changed),
      .out_accepted      (rsp_ch.accepted),
      .out_is_playing    (rsp_ch.is_playing)
   );

endmodule
